// ===== rtl/mts_pkg.sv =====
// shared types and codes for the min tracking stack
package mts_pkg;

  // input item kinds
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [1:0] ST_PUSH_FULL = 2'd2;

  // fixed field widths on the ports
  localparam int FIELD_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int OUT_TDATA_W = 56;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FIX  = 2'b10
  } state_t;

endpackage

// ===== rtl/min_tracking_stack_top.sv =====
// min tracking stack: value and minimum stacks in memories, tops in registers
//
// A push, a pop on an empty stack and a push on a full stack each go from
// acceptance straight into the output register. A pop that removes a value
// passes through S_FIX: the entries below the tops are read from the value
// memory and the minimum memory at acceptance; in S_FIX the value read data become the new top, and
// the minimum read data the new minimum if the popped value was the minimum. One item is in work at a time;
// a new item is taken while the previous result is being handed over. The
// memories need no clearing after reset, as the counts only address written
// entries.
module min_tracking_stack_top #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mts_pkg::FIELD_W-1:0]         in_tdata,   // [15:0] push_value
  input  logic [0:0]                          in_tuser,   // [0] command
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [15:0] popped_value, [31:16] top_value, [47:32] min_value, [48] is_empty,
  // [55:49] zero
  output logic [mts_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [mts_pkg::STATUS_W-1:0]        out_tuser   // [1:0] status
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FW = mts_pkg::FIELD_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // storage
  logic [DATA_WIDTH-1:0] val_mem [DEPTH];
  logic [DATA_WIDTH-1:0] min_mem [DEPTH];
  logic [DATA_WIDTH-1:0] val_rdata_r;
  logic [DATA_WIDTH-1:0] min_rdata_r;

  // control and top registers
  mts_pkg::state_t       state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         min_cnt_r, min_cnt_nxt;
  logic [DATA_WIDTH-1:0] top_r, top_nxt;
  logic [DATA_WIDTH-1:0] min_top_r, min_top_nxt;
  logic [DATA_WIDTH-1:0] popped_r;
  logic                  min_hit_r;
  logic                  out_valid_r, out_valid_nxt;

  // output payload registers
  logic [FW-1:0]                  out_popped_r, out_popped_nxt;
  logic [FW-1:0]                  out_top_r, out_top_nxt;
  logic [FW-1:0]                  out_min_r, out_min_nxt;
  logic                           out_empty_r, out_empty_nxt;
  logic [mts_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;

  // decode of the accepted item
  logic                  in_acc;
  logic                  is_push;
  logic                  push_ok;
  logic                  push_full;
  logic                  pop_ok;
  logic                  min_push;
  logic                  min_hit;
  logic [DATA_WIDTH-1:0] push_val;
  logic [DATA_WIDTH+FW-1:0] push_ext;
  logic [CW-1:0]         cnt_m2;
  logic [CW-1:0]         min_cnt_m2;
  logic                  out_free;

  // width adaption between port fields and storage
  function automatic logic [FW-1:0] to_field(input logic [DATA_WIDTH-1:0] d);
    logic [DATA_WIDTH+FW-1:0] ext;
    ext = {{FW{1'b0}}, d};
    return ext[FW-1:0];
  endfunction

  assign push_ext = {{DATA_WIDTH{1'b0}}, in_tdata};
  assign push_val = push_ext[DATA_WIDTH-1:0];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == mts_pkg::S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign is_push   = (in_tuser[0] == mts_pkg::CMD_PUSH);
  assign push_full = is_push && (cnt_r == FULL_CNT);
  assign push_ok   = is_push && (cnt_r != FULL_CNT);
  assign pop_ok    = !is_push && (cnt_r != '0);
  assign min_push  = push_ok && ((min_cnt_r == '0) || (push_val <= min_top_r));
  assign min_hit   = (top_r == min_top_r);
  assign cnt_m2     = cnt_r - CW'(2);
  assign min_cnt_m2 = min_cnt_r - CW'(2);

  // value memory: push writes, pop reads the entry below the top
  always_ff @(posedge clk) begin
    if (in_acc && push_ok) begin
      val_mem[cnt_r[IW-1:0]] <= push_val;
    end
    val_rdata_r <= val_mem[cnt_m2[IW-1:0]];
  end

  // minimum memory: same access pattern on its own count
  always_ff @(posedge clk) begin
    if (in_acc && min_push) begin
      min_mem[min_cnt_r[IW-1:0]] <= push_val;
    end
    min_rdata_r <= min_mem[min_cnt_m2[IW-1:0]];
  end

  // next state and result
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    min_cnt_nxt    = min_cnt_r;
    top_nxt        = top_r;
    min_top_nxt    = min_top_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_popped_nxt = out_popped_r;
    out_top_nxt    = out_top_r;
    out_min_nxt    = out_min_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      mts_pkg::S_IDLE: begin
        if (in_acc) begin
          if (push_ok) begin
            cnt_nxt        = cnt_r + CW'(1);
            top_nxt        = push_val;
            if (min_push) begin
              min_cnt_nxt = min_cnt_r + CW'(1);
              min_top_nxt = push_val;
            end
            out_valid_nxt  = 1'b1;
            out_popped_nxt = '0;
            out_top_nxt    = to_field(push_val);
            out_min_nxt    = min_push ? to_field(push_val) : to_field(min_top_r);
            out_empty_nxt  = 1'b0;
            out_status_nxt = mts_pkg::ST_OK;
          end else if (push_full) begin
            out_valid_nxt  = 1'b1;
            out_popped_nxt = '0;
            out_top_nxt    = to_field(top_r);
            out_min_nxt    = to_field(min_top_r);
            out_empty_nxt  = 1'b0;
            out_status_nxt = mts_pkg::ST_PUSH_FULL;
          end else if (pop_ok) begin
            cnt_nxt = cnt_r - CW'(1);
            if (min_hit) begin
              min_cnt_nxt = min_cnt_r - CW'(1);
            end
            state_nxt = mts_pkg::S_FIX;
          end else begin
            out_valid_nxt  = 1'b1;
            out_popped_nxt = '0;
            out_top_nxt    = '0;
            out_min_nxt    = '0;
            out_empty_nxt  = 1'b1;
            out_status_nxt = mts_pkg::ST_POP_EMPTY;
          end
        end
      end
      mts_pkg::S_FIX: begin
        // read data of the entries below the old tops is here
        top_nxt = val_rdata_r;
        if (min_hit_r) begin
          min_top_nxt = min_rdata_r;
        end
        out_valid_nxt  = 1'b1;
        out_popped_nxt = to_field(popped_r);
        out_empty_nxt  = (cnt_r == '0);
        out_top_nxt    = (cnt_r == '0) ? '0 : to_field(val_rdata_r);
        out_min_nxt    = (cnt_r == '0) ? '0 :
                         (min_hit_r ? to_field(min_rdata_r) : to_field(min_top_r));
        out_status_nxt = mts_pkg::ST_OK;
        state_nxt      = mts_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mts_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mts_pkg::S_IDLE;
      cnt_r       <= '0;
      min_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      min_cnt_r   <= min_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r        <= top_nxt;
    min_top_r    <= min_top_nxt;
    out_popped_r <= out_popped_nxt;
    out_top_r    <= out_top_nxt;
    out_min_r    <= out_min_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
    if (in_acc) begin
      popped_r  <= top_r;
      min_hit_r <= min_hit;
    end
  end

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_empty_r, out_min_r, out_top_r, out_popped_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the min tracking stack: directed and random push/pop items
`timescale 1ns / 100ps

module tb_top;

  localparam int STACK_DEPTH = 64;
  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS = 850;

  // one result as the block should report it
  typedef struct packed {
    logic [mts_pkg::FIELD_W-1:0]  popped_value;
    logic [mts_pkg::FIELD_W-1:0]  top_value;
    logic [mts_pkg::FIELD_W-1:0]  min_value;
    logic                         is_empty;
    logic [mts_pkg::STATUS_W-1:0] status;
  } stack_result_t;

  // predicts stack results and checks the block's output against them
  class stack_scoreboard;
    logic [mts_pkg::FIELD_W-1:0] values[STACK_DEPTH];
    logic [mts_pkg::FIELD_W-1:0] mins[STACK_DEPTH];
    int unsigned n_values;
    int unsigned n_mins;
    stack_result_t expected_results[$];
    int mismatches;
    int checked;
    int full_pushes;
    int empty_pops;
    int min_pops;
    int deepest;

    function new();
      n_values = 0;
      n_mins = 0;
      mismatches = 0;
      checked = 0;
      full_pushes = 0;
      empty_pops = 0;
      min_pops = 0;
      deepest = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // apply one accepted item to the shadow stacks and queue its result
    function void note_input(logic cmd, logic [mts_pkg::FIELD_W-1:0] value);
      stack_result_t res;
      res = '0;
      res.status = mts_pkg::ST_OK;
      if (cmd == mts_pkg::CMD_PUSH) begin
        if (n_values >= STACK_DEPTH) begin
          res.status = mts_pkg::ST_PUSH_FULL;
          full_pushes++;
        end else begin
          values[n_values] = value;
          n_values++;
          if (n_mins == 0) begin
            mins[0] = value;
            n_mins = 1;
          end else if (n_mins < STACK_DEPTH && value <= mins[n_mins-1]) begin
            mins[n_mins] = value;
            n_mins++;
          end
        end
      end else begin
        if (n_values == 0) begin
          res.status = mts_pkg::ST_POP_EMPTY;
          empty_pops++;
        end else begin
          res.popped_value = values[n_values-1];
          n_values--;
          if (n_mins > 0 && res.popped_value == mins[n_mins-1]) begin
            n_mins--;
            min_pops++;
          end
        end
      end
      if (n_values > deepest) deepest = n_values;
      res.is_empty = (n_values == 0);
      res.top_value = (n_values == 0) ? '0 : values[n_values-1];
      res.min_value = (n_values == 0 || n_mins == 0) ? '0 : mins[n_mins-1];
      expected_results.push_back(res);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(logic [mts_pkg::OUT_TDATA_W-1:0] tdata,
                               logic [mts_pkg::STATUS_W-1:0] tuser);
      stack_result_t exp_res;
      stack_result_t act;
      logic [mts_pkg::OUT_TDATA_W-50:0] pad;
      act.popped_value = tdata[15:0];
      act.top_value = tdata[31:16];
      act.min_value = tdata[47:32];
      act.is_empty = tdata[48];
      act.status = tuser;
      pad = tdata[mts_pkg::OUT_TDATA_W-1:49];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: popped %h top %h min %h empty %b status %0d",
                   $realtime, act.popped_value, act.top_value, act.min_value, act.is_empty,
                   act.status);
        return;
      end
      exp_res = expected_results.pop_front();
      checked++;
      if (act.popped_value !== exp_res.popped_value || act.top_value !== exp_res.top_value ||
          act.min_value !== exp_res.min_value || act.is_empty !== exp_res.is_empty ||
          act.status !== exp_res.status || pad !== '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch on result %0d", $realtime, checked);
          $display("  expected popped %h top %h min %h empty %b status %0d pad 0",
                   exp_res.popped_value, exp_res.top_value, exp_res.min_value,
                   exp_res.is_empty, exp_res.status);
          $display("  actual   popped %h top %h min %h empty %b status %0d pad %h",
                   act.popped_value, act.top_value, act.min_value, act.is_empty,
                   act.status, pad);
        end
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [mts_pkg::FIELD_W-1:0]     in_tdata;   // [15:0] push_value
  logic [0:0]                      in_tuser;   // [0] command
  logic                            out_tvalid;
  logic                            out_tready;
  // [15:0] popped_value, [31:16] top_value, [47:32] min_value, [48] is_empty, [55:49] zero
  logic [mts_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [mts_pkg::STATUS_W-1:0]    out_tuser;  // [1:0] status

  stack_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_requests;
  int items_sent;
  logic [mts_pkg::FIELD_W-1:0] last_value;

  min_tracking_stack_top #(
    .DEPTH     (STACK_DEPTH),
    .DATA_WIDTH(mts_pkg::FIELD_W)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random back-pressure plus long hold-offs on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result monitor
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
    end
  end

  // offer one item, with random gaps ahead of it, and wait for acceptance
  task automatic send_item(input logic cmd, input logic [mts_pkg::FIELD_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= value;
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, value);
    items_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // extremes, duplicate minimums and pops on an empty stack
  task automatic run_directed();
    send_item(mts_pkg::CMD_POP, 16'hFFFF);
    send_item(mts_pkg::CMD_PUSH, 16'hFFFF);
    send_item(mts_pkg::CMD_PUSH, 16'h0000);
    send_item(mts_pkg::CMD_PUSH, 16'h0000);
    send_item(mts_pkg::CMD_PUSH, 16'h8000);
    send_item(mts_pkg::CMD_POP, 16'($urandom));
    send_item(mts_pkg::CMD_POP, 16'($urandom));
    send_item(mts_pkg::CMD_POP, 16'($urandom));
    send_item(mts_pkg::CMD_POP, 16'($urandom));
    send_item(mts_pkg::CMD_POP, 16'h0000);
    send_item(mts_pkg::CMD_PUSH, 16'h5555);
    send_item(mts_pkg::CMD_PUSH, 16'hAAAA);
    send_item(mts_pkg::CMD_PUSH, 16'h5555);
    send_item(mts_pkg::CMD_PUSH, 16'h5554);
    send_item(mts_pkg::CMD_PUSH, 16'h7FFF);
    send_item(mts_pkg::CMD_POP, 16'($urandom));
    send_item(mts_pkg::CMD_POP, 16'($urandom));
    send_item(mts_pkg::CMD_POP, 16'($urandom));
    send_item(mts_pkg::CMD_POP, 16'($urandom));
    send_item(mts_pkg::CMD_POP, 16'($urandom));
    send_item(mts_pkg::CMD_POP, 16'($urandom));
  endtask

  // value for a push in the given style
  function automatic logic [mts_pkg::FIELD_W-1:0] pick_value(int style);
    logic [mts_pkg::FIELD_W-1:0] v;
    int step;
    case (style)
      1: v = 16'($urandom_range(7));
      2: begin
        step = $urandom_range(300);
        v = (last_value > step) ? last_value - 16'(step) : 16'hFFFF - 16'($urandom_range(255));
      end
      3: begin
        case ($urandom_range(3))
          0: v = 16'h0000;
          1: v = 16'hFFFF;
          2: v = 16'h8000;
          default: v = 16'h7FFF;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    last_value = v;
    return v;
  endfunction

  // bursts of pushes, pops and mixes; each phase opens by filling the stack past full
  task automatic run_random(input int n_items);
    int done;
    int burst;
    int push_pct;
    int style;
    logic cmd;
    done = 0;
    burst = STACK_DEPTH + 6;
    push_pct = 100;
    style = $urandom_range(3);
    while (done < n_items) begin
      if (burst == 0) begin
        style = $urandom_range(3);
        case ($urandom_range(3))
          0: begin
            push_pct = 92;
            burst = $urandom_range(80, 20);
          end
          1: begin
            push_pct = 8;
            burst = $urandom_range(70, 10);
          end
          2: begin
            push_pct = 55;
            burst = $urandom_range(60, 20);
          end
          default: begin
            push_pct = 50;
            burst = $urandom_range(20, 5);
          end
        endcase
      end
      cmd = ($urandom_range(99) < push_pct) ? mts_pkg::CMD_PUSH : mts_pkg::CMD_POP;
      // long receiver hold-off while items keep coming
      if (done == n_items / 2) hold_requests++;
      send_item(cmd, (cmd == mts_pkg::CMD_PUSH) ? pick_value(style) : 16'($urandom));
      done++;
      burst--;
    end
  endtask

  // stimulus sequence
  initial begin
    sb = new();
    tx_idle_pct = 24;
    rx_idle_pct = 83;
    hold_requests = 0;
    items_sent = 0;
    last_value = 16'hFFFF;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= mts_pkg::CMD_PUSH;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(RANDOM_ITEMS / 3);
    drain();

    tx_idle_pct = 83;
    rx_idle_pct = 24;
    run_random(RANDOM_ITEMS / 3);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run: %0d items in, %0d results checked, deepest stack %0d of %0d",
             items_sent, sb.checked, sb.deepest, STACK_DEPTH);
    $display("run: %0d pushes on full, %0d pops on empty, %0d minimum removals, %0d mismatches",
             sb.full_pushes, sb.empty_pops, sb.min_pops, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mts_pkg.sv
rtl/min_tracking_stack_top.sv
dv/tb_top.sv
